@@ hdl/dbsc_pkg.sv @@
// Package for the display buffer swap chain: widths, codes, request and
// result records, and the small constant tables of the layout logic.
// No dependencies; every other file of the block depends on it.
`timescale 1ns / 1ps

package dbsc_pkg;

  localparam int unsigned MAX_BUFFERS_DEF = 8;
  localparam int unsigned CFG_COUNT_MAX   = 15;

  localparam int unsigned KIND_W = 3;
  localparam int unsigned XPOS_W = 12;
  localparam int unsigned YPOS_W = 11;
  localparam int unsigned QIDX_W = 8;
  localparam int unsigned DIM_W  = 12;
  localparam int unsigned FMT_W  = 5;
  localparam int unsigned BCNT_W = 4;
  localparam int unsigned WORD_W = 64;
  localparam int unsigned BASE_W = 32;
  localparam int unsigned OIDX_W = 3;
  localparam int unsigned CTR_W  = 8;
  localparam int unsigned PIX_W  = 24;
  localparam int unsigned WK_W   = 6;
  localparam int unsigned MULB_W = 12;
  localparam int unsigned APB_AW = 5;
  localparam int unsigned APB_DW = 32;

  typedef enum logic [KIND_W-1:0] {
    KIND_SETUP,
    KIND_SWAP,
    KIND_DRAW_DONE,
    KIND_DISP_NEXT,
    KIND_NEXT_DRAW,
    KIND_SET_POS,
    KIND_QUERY,
    KIND_NONE
  } kind_e;

  typedef enum logic [2:0] {
    REG_FRAME_WIDTH,
    REG_FRAME_HEIGHT,
    REG_PIXEL_FORMAT,
    REG_BUFFER_COUNT,
    REG_ZBUF_ENABLE,
    REG_ZBUF_FORMAT
  } reg_e;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,
    OP_LATCH,
    OP_UPDATE,
    OP_PIX,
    OP_FRAME,
    OP_ZBUF,
    OP_TEX,
    OP_DRAW_BASE,
    OP_SHOW_BASE,
    OP_QUERY_BASE,
    OP_EMIT
  } dp_op_e;

  typedef enum logic [3:0] {
    MUL_HOLD,
    MUL_PIX,
    MUL_FRAME,
    MUL_ZBUF,
    MUL_TEX,
    MUL_DRAW,
    MUL_SHOW,
    MUL_QUERY,
    MUL_GEOM
  } mul_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_PIX,
    ST_FRAME,
    ST_ZBUF,
    ST_TEX,
    ST_TEX_SUM,
    ST_BASE0,
    ST_BASE1,
    ST_BASE2,
    ST_BASE3,
    ST_EMIT
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e   op;
    mul_sel_e msel;
  } dp_cmd_t;

  typedef struct packed {
    logic is_setup;
    logic out_free;
  } dp_stat_t;

  typedef struct packed {
    logic [DIM_W-1:0]  frame_width;
    logic [DIM_W-1:0]  frame_height;
    logic [FMT_W-1:0]  pixel_format;
    logic [BCNT_W-1:0] buffer_count;
    logic              zbuffer_enable;
    logic [FMT_W-1:0]  zbuffer_format;
  } cfg_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [XPOS_W-1:0] x_position;
    logic [YPOS_W-1:0] y_position;
    logic [QIDX_W-1:0] buffer_index;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] display_fb_word;
    logic              display_fb_write;
    logic [WORD_W-1:0] display_geom_word;
    logic              display_geom_write;
    logic [BASE_W-1:0] draw_frame_base;
    logic              draw_frame_write;
    logic [BASE_W-1:0] queried_base;
    logic [BASE_W-1:0] texture_base;
    logic [OIDX_W-1:0] display_index;
    logic [OIDX_W-1:0] draw_index;
    logic              draw_available;
    logic              display_available;
  } out_item_t;

  function automatic logic [2:0] pix_bytes(input logic [FMT_W-1:0] fmt);
    logic [2:0] b;
    if (fmt == 5'd0) begin
      b = 3'd4;
    end else if (fmt == 5'd1 || fmt == 5'd18) begin
      b = 3'd3;
    end else if (fmt == 5'd2 || fmt == 5'd10) begin
      b = 3'd2;
    end else begin
      b = 3'd1;
    end
    return b;
  endfunction

  function automatic logic [BASE_W-1:0] round_32k(input logic [BASE_W-1:0] size);
    logic [BASE_W-1:0] r;
    if (size[14:0] != 15'd0) begin
      r = {size[BASE_W-1:15], 15'd0} + 32'h0000_8000;
    end else begin
      r = size;
    end
    return r;
  endfunction

  // Horizontal magnification terms for a width of 64*k pixels: floor(40/k) and
  // ceil(40/k)-1, both zero for k = 0.
  function automatic logic [5:0] mag_div(input logic [WK_W-1:0] k);
    logic [5:0] m;
    priority if (k == 6'd0) m = 6'd0;
    else if (k >= 6'd41) m = 6'd0;
    else if (k >= 6'd21) m = 6'd1;
    else if (k >= 6'd14) m = 6'd2;
    else if (k >= 6'd11) m = 6'd3;
    else if (k >= 6'd9)  m = 6'd4;
    else if (k >= 6'd7)  m = 6'd5;
    else if (k == 6'd6)  m = 6'd6;
    else if (k == 6'd5)  m = 6'd8;
    else if (k == 6'd4)  m = 6'd10;
    else if (k == 6'd3)  m = 6'd13;
    else if (k == 6'd2)  m = 6'd20;
    else                 m = 6'd40;
    return m;
  endfunction

  function automatic logic [5:0] mag_h(input logic [WK_W-1:0] k);
    logic [5:0] m;
    priority if (k == 6'd0) m = 6'd0;
    else if (k >= 6'd40) m = 6'd0;
    else if (k >= 6'd20) m = 6'd1;
    else if (k >= 6'd14) m = 6'd2;
    else if (k >= 6'd10) m = 6'd3;
    else if (k >= 6'd8)  m = 6'd4;
    else if (k == 6'd7)  m = 6'd5;
    else if (k == 6'd6)  m = 6'd6;
    else if (k == 6'd5)  m = 6'd7;
    else if (k == 6'd4)  m = 6'd9;
    else if (k == 6'd3)  m = 6'd13;
    else if (k == 6'd2)  m = 6'd19;
    else                 m = 6'd39;
    return m;
  endfunction

endpackage

@@ hdl/dbsc_if.sv @@
// Valid/ready channel interfaces for the swap chain requests and results.
// Depends on dbsc_pkg for the field widths.
`timescale 1ns / 1ps

interface dbsc_in_if;
  logic                         valid;
  logic                         ready;
  logic [dbsc_pkg::KIND_W-1:0]  kind;
  logic [dbsc_pkg::XPOS_W-1:0]  x_position;
  logic [dbsc_pkg::YPOS_W-1:0]  y_position;
  logic [dbsc_pkg::QIDX_W-1:0]  buffer_index;

  modport source (output valid, kind, x_position, y_position, buffer_index, input ready);
  modport sink (input valid, kind, x_position, y_position, buffer_index, output ready);
endinterface

interface dbsc_out_if;
  logic                         valid;
  logic                         ready;
  logic [dbsc_pkg::WORD_W-1:0]  display_fb_word;
  logic                         display_fb_write;
  logic [dbsc_pkg::WORD_W-1:0]  display_geom_word;
  logic                         display_geom_write;
  logic [dbsc_pkg::BASE_W-1:0]  draw_frame_base;
  logic                         draw_frame_write;
  logic [dbsc_pkg::BASE_W-1:0]  queried_base;
  logic [dbsc_pkg::BASE_W-1:0]  texture_base;
  logic [dbsc_pkg::OIDX_W-1:0]  display_index;
  logic [dbsc_pkg::OIDX_W-1:0]  draw_index;
  logic                         draw_available;
  logic                         display_available;

  modport source (
    output valid, display_fb_word, display_fb_write, display_geom_word,
    display_geom_write, draw_frame_base, draw_frame_write, queried_base,
    texture_base, display_index, draw_index, draw_available, display_available,
    input ready
  );
  modport sink (
    input valid, display_fb_word, display_fb_write, display_geom_word,
    display_geom_write, draw_frame_base, draw_frame_write, queried_base,
    texture_base, display_index, draw_index, draw_available, display_available,
    output ready
  );
endinterface

@@ hdl/display_buffer_swap_chain_top.sv @@
// Top level of the display buffer swap chain: register port, sequencer and
// datapath. Depends on dbsc_pkg, dbsc_if, dbsc_ctrl and dbsc_dp.
//
//   Port      Direction  Handshake            Carries
//   in_if     sink       valid / ready        kind, positions, queried buffer
//   out_if    source     valid / ready        display words, bases, ring status
//   psel ...  slave      psel/penable/pready  six layout registers
//
// A request is worked through a sequence of steps on the one shared multiplier;
// a setup request runs more of those steps than the other requests.
// Requests are taken one at a time: the next one is accepted in the cycle after
// the previous result is loaded, even while that result still waits downstream.
// After reset the block takes requests at once; registers hold their defaults.
`timescale 1ns / 1ps

module display_buffer_swap_chain_top #(
  parameter int unsigned MAX_BUFFERS = dbsc_pkg::MAX_BUFFERS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  dbsc_in_if.sink                       in_if,
  dbsc_out_if.source                    out_if,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dbsc_pkg::APB_AW-1:0]   paddr,
  input  logic [dbsc_pkg::APB_DW-1:0]   pwdata,
  output logic [dbsc_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import dbsc_pkg::*;

  cfg_t      cfg_q;
  dp_cmd_t   dp_cmd;
  dp_stat_t  dp_stat;
  in_item_t  in_item;
  out_item_t out_item;
  logic      in_ready;
  logic      out_valid;
  logic      cfg_wr;
  reg_e      reg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = reg_e'(paddr[APB_AW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width    <= DIM_W'(320);
      cfg_q.frame_height   <= DIM_W'(240);
      cfg_q.pixel_format   <= '0;
      cfg_q.buffer_count   <= BCNT_W'(2);
      cfg_q.zbuffer_enable <= 1'b1;
      cfg_q.zbuffer_format <= '0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_FRAME_WIDTH:  cfg_q.frame_width    <= pwdata[DIM_W-1:0];
        REG_FRAME_HEIGHT: cfg_q.frame_height   <= pwdata[DIM_W-1:0];
        REG_PIXEL_FORMAT: cfg_q.pixel_format   <= pwdata[FMT_W-1:0];
        REG_BUFFER_COUNT: cfg_q.buffer_count   <= pwdata[BCNT_W-1:0];
        REG_ZBUF_ENABLE:  cfg_q.zbuffer_enable <= pwdata[0];
        REG_ZBUF_FORMAT:  cfg_q.zbuffer_format <= pwdata[FMT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_FRAME_WIDTH:  prdata = APB_DW'(cfg_q.frame_width);
      REG_FRAME_HEIGHT: prdata = APB_DW'(cfg_q.frame_height);
      REG_PIXEL_FORMAT: prdata = APB_DW'(cfg_q.pixel_format);
      REG_BUFFER_COUNT: prdata = APB_DW'(cfg_q.buffer_count);
      REG_ZBUF_ENABLE:  prdata = APB_DW'(cfg_q.zbuffer_enable);
      REG_ZBUF_FORMAT:  prdata = APB_DW'(cfg_q.zbuffer_format);
      default:          prdata = '0;
    endcase
  end

  assign in_item.kind         = in_if.kind;
  assign in_item.x_position   = in_if.x_position;
  assign in_item.y_position   = in_if.y_position;
  assign in_item.buffer_index = in_if.buffer_index;
  assign in_if.ready          = in_ready;

  dbsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_ready),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  dbsc_dp #(
    .MAX_BUFFERS (MAX_BUFFERS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .stat_o      (dp_stat),
    .cfg_i       (cfg_q),
    .in_item_i   (in_item),
    .out_ready_i (out_if.ready),
    .out_valid_o (out_valid),
    .out_item_o  (out_item)
  );

  assign out_if.valid              = out_valid;
  assign out_if.display_fb_word    = out_item.display_fb_word;
  assign out_if.display_fb_write   = out_item.display_fb_write;
  assign out_if.display_geom_word  = out_item.display_geom_word;
  assign out_if.display_geom_write = out_item.display_geom_write;
  assign out_if.draw_frame_base    = out_item.draw_frame_base;
  assign out_if.draw_frame_write   = out_item.draw_frame_write;
  assign out_if.queried_base       = out_item.queried_base;
  assign out_if.texture_base       = out_item.texture_base;
  assign out_if.display_index      = out_item.display_index;
  assign out_if.draw_index         = out_item.draw_index;
  assign out_if.draw_available     = out_item.draw_available;
  assign out_if.display_available  = out_item.display_available;

`ifndef SYNTH
  a_one_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.valid && in_if.ready |=> !in_if.ready)
    else $error("A second request was accepted right after the first.");

  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.valid && in_if.ready |=> !$rose(out_if.valid))
    else $error("A result appeared in the cycle after a request was accepted.");

  a_emit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.op == OP_EMIT |=> out_if.valid)
    else $error("A loaded result was not presented.");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_if.valid) |-> $past(dp_cmd.op == OP_EMIT))
    else $error("A result was presented without being loaded.");
`endif

endmodule

@@ hdl/dbsc_ctrl.sv @@
// Sequencer of the swap chain: walks each request through the shared
// multiplier steps and issues datapath commands. Depends on dbsc_pkg.
`timescale 1ns / 1ps

module dbsc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  dbsc_pkg::dp_stat_t stat_i,
  output dbsc_pkg::dp_cmd_t  cmd_o
);
  import dbsc_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o.op   = OP_IDLE;
    cmd_o.msel = MUL_HOLD;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (stat_i.is_setup) begin
          cmd_o.op = OP_LATCH;
          state_d  = ST_PIX;
        end else begin
          cmd_o.op = OP_UPDATE;
          state_d  = ST_BASE0;
        end
      end
      ST_PIX: begin
        cmd_o.msel = MUL_PIX;
        state_d    = ST_FRAME;
      end
      ST_FRAME: begin
        cmd_o.op   = OP_PIX;
        cmd_o.msel = MUL_FRAME;
        state_d    = ST_ZBUF;
      end
      ST_ZBUF: begin
        cmd_o.op   = OP_FRAME;
        cmd_o.msel = MUL_ZBUF;
        state_d    = ST_TEX;
      end
      ST_TEX: begin
        cmd_o.op   = OP_ZBUF;
        cmd_o.msel = MUL_TEX;
        state_d    = ST_TEX_SUM;
      end
      ST_TEX_SUM: begin
        cmd_o.op   = OP_TEX;
        cmd_o.msel = MUL_DRAW;
        state_d    = ST_BASE1;
      end
      ST_BASE0: begin
        cmd_o.msel = MUL_DRAW;
        state_d    = ST_BASE1;
      end
      ST_BASE1: begin
        cmd_o.op   = OP_DRAW_BASE;
        cmd_o.msel = MUL_SHOW;
        state_d    = ST_BASE2;
      end
      ST_BASE2: begin
        cmd_o.op   = OP_SHOW_BASE;
        cmd_o.msel = MUL_QUERY;
        state_d    = ST_BASE3;
      end
      ST_BASE3: begin
        cmd_o.op   = OP_QUERY_BASE;
        cmd_o.msel = MUL_GEOM;
        state_d    = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_EMIT;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ hdl/dbsc_dp.sv @@
// Datapath of the swap chain: layout and ring state, the shared multiplier,
// the per-request staging and the result register. Depends on dbsc_pkg.
`timescale 1ns / 1ps

module dbsc_dp #(
  parameter int unsigned MAX_BUFFERS = dbsc_pkg::MAX_BUFFERS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dbsc_pkg::dp_cmd_t   cmd_i,
  output dbsc_pkg::dp_stat_t  stat_o,
  input  dbsc_pkg::cfg_t      cfg_i,
  input  dbsc_pkg::in_item_t  in_item_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output dbsc_pkg::out_item_t out_item_o
);
  import dbsc_pkg::*;

  localparam int unsigned CNT_MAX = (MAX_BUFFERS < CFG_COUNT_MAX) ? MAX_BUFFERS : CFG_COUNT_MAX;
  localparam int unsigned IDX_W   = (CNT_MAX > 1) ? $clog2(CNT_MAX) : 1;
  localparam int unsigned CNT_W   = $clog2(CNT_MAX + 1);

  logic [CNT_W-1:0]  lay_cnt_q;
  logic [WK_W-1:0]   lay_k_q;
  logic [DIM_W-1:0]  lay_height_q;
  logic [FMT_W-1:0]  lay_fmt_q;
  logic [XPOS_W-1:0] x_off_q;
  logic [YPOS_W-1:0] y_off_q;
  logic [IDX_W-1:0]  shown_q;
  logic [IDX_W-1:0]  drawn_q;
  logic [CTR_W-1:0]  free_q;
  logic [CTR_W-1:0]  done_q;
  logic [BASE_W-1:0] frame_q;
  logic [BASE_W-1:0] tex_q;
  logic              out_valid_q;

  logic [KIND_W-1:0] kind_q;
  logic [XPOS_W-1:0] xin_q;
  logic [YPOS_W-1:0] yin_q;
  logic [QIDX_W-1:0] qidx_q;
  logic              fb_wr_q;
  logic              geom_wr_q;
  logic              draw_wr_q;
  logic [PIX_W-1:0]  pix_q;
  logic [BASE_W-1:0] zsize_q;
  logic [BASE_W-1:0] mul_q;
  logic [BASE_W-1:0] draw_base_q;
  logic [BASE_W-1:0] show_base_q;
  logic [BASE_W-1:0] query_base_q;
  out_item_t         out_q;

  logic [CNT_W-1:0]  cnt_m1;
  logic [BCNT_W-1:0] n_sel;
  logic [CNT_W-1:0]  n_lat;
  logic              do_done, do_disp, do_next, do_pos;
  logic [CTR_W-1:0]  done_a, done_b, free_a, free_b;
  logic              disp_go, next_go;
  logic [IDX_W:0]    shown_inc, drawn_inc;
  logic [IDX_W-1:0]  shown_n, drawn_n;
  logic [QIDX_W-1:0] qidx_cl;
  logic [BASE_W-1:0] mul_a;
  logic [MULB_W-1:0] mul_b;
  logic [BASE_W+MULB_W-1:0] mul_p;
  logic [WORD_W-1:0] fb_word, geom_word;
  logic [IDX_W+OIDX_W-1:0] shown_x, drawn_x;

  assign cnt_m1 = lay_cnt_q - CNT_W'(1);

  assign n_sel = (cfg_i.buffer_count == '0) ? BCNT_W'(1) : cfg_i.buffer_count;
  assign n_lat = (32'(n_sel) > MAX_BUFFERS) ? CNT_W'(MAX_BUFFERS) : CNT_W'(n_sel);

  // Ring update: draw complete, then display next, then next draw.
  always_comb begin
    do_done = (kind_q == KIND_SWAP) || (kind_q == KIND_DRAW_DONE);
    do_disp = (kind_q == KIND_SWAP) || (kind_q == KIND_DISP_NEXT);
    do_next = (kind_q == KIND_SWAP) || (kind_q == KIND_NEXT_DRAW);
    do_pos  = (kind_q == KIND_SET_POS);

    done_a = (do_done && (done_q < CTR_W'(cnt_m1))) ? done_q + CTR_W'(1) : done_q;
    disp_go = do_disp && (done_a != '0);
    shown_inc = {1'b0, shown_q} + (IDX_W+1)'(1);
    if (!disp_go) begin
      shown_n = shown_q;
    end else if (shown_inc > (IDX_W+1)'(cnt_m1)) begin
      shown_n = '0;
    end else begin
      shown_n = shown_inc[IDX_W-1:0];
    end
    done_b = disp_go ? done_a - CTR_W'(1) : done_a;
    free_a = disp_go ? free_q + CTR_W'(1) : free_q;

    next_go = do_next && (free_a != '0);
    drawn_inc = {1'b0, drawn_q} + (IDX_W+1)'(1);
    if (!next_go) begin
      drawn_n = drawn_q;
    end else if (drawn_inc > (IDX_W+1)'(cnt_m1)) begin
      drawn_n = '0;
    end else begin
      drawn_n = drawn_inc[IDX_W-1:0];
    end
    free_b = next_go ? free_a - CTR_W'(1) : free_a;
  end

  assign qidx_cl = (qidx_q > QIDX_W'(cnt_m1)) ? QIDX_W'(cnt_m1) : qidx_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.msel)
      MUL_PIX: begin
        mul_a = BASE_W'({lay_k_q, 6'd0});
        mul_b = MULB_W'(lay_height_q);
      end
      MUL_FRAME: begin
        mul_a = mul_q;
        mul_b = MULB_W'(pix_bytes(lay_fmt_q));
      end
      MUL_ZBUF: begin
        mul_a = BASE_W'(pix_q);
        mul_b = cfg_i.zbuffer_enable ? MULB_W'(pix_bytes(cfg_i.zbuffer_format)) : '0;
      end
      MUL_TEX: begin
        mul_a = frame_q;
        mul_b = MULB_W'(lay_cnt_q);
      end
      MUL_DRAW: begin
        mul_a = frame_q;
        mul_b = MULB_W'(drawn_q);
      end
      MUL_SHOW: begin
        mul_a = frame_q;
        mul_b = MULB_W'(shown_q);
      end
      MUL_QUERY: begin
        mul_a = frame_q;
        mul_b = MULB_W'(qidx_cl);
      end
      MUL_GEOM: begin
        mul_a = BASE_W'(x_off_q);
        mul_b = MULB_W'(mag_div(lay_k_q));
      end
      MUL_HOLD: begin
        mul_a = '0;
        mul_b = '0;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = (BASE_W+MULB_W)'(mul_a) * (BASE_W+MULB_W)'(mul_b);

  always_ff @(posedge clk_i) begin
    if (cmd_i.msel != MUL_HOLD) begin
      mul_q <= mul_p[BASE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lay_cnt_q    <= CNT_W'(1);
      lay_k_q      <= '0;
      lay_height_q <= '0;
      lay_fmt_q    <= '0;
      x_off_q      <= '0;
      y_off_q      <= '0;
      shown_q      <= '0;
      drawn_q      <= '0;
      free_q       <= '0;
      done_q       <= '0;
      frame_q      <= '0;
      tex_q        <= '0;
    end else begin
      unique case (cmd_i.op)
        OP_LATCH: begin
          lay_cnt_q    <= n_lat;
          lay_k_q      <= cfg_i.frame_width[DIM_W-1:6];
          lay_height_q <= cfg_i.frame_height;
          lay_fmt_q    <= cfg_i.pixel_format;
          x_off_q      <= xin_q;
          y_off_q      <= yin_q;
          shown_q      <= '0;
          drawn_q      <= (n_lat > CNT_W'(1)) ? IDX_W'(1) : '0;
          free_q       <= CTR_W'(n_lat) - CTR_W'(2);
        end
        OP_UPDATE: begin
          done_q  <= done_b;
          free_q  <= free_b;
          shown_q <= shown_n;
          drawn_q <= drawn_n;
          if (do_pos) begin
            x_off_q <= xin_q;
            y_off_q <= yin_q;
          end
        end
        OP_FRAME: begin
          frame_q <= round_32k(mul_q);
        end
        OP_TEX: begin
          tex_q <= mul_q + zsize_q;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        kind_q    <= in_item_i.kind;
        xin_q     <= in_item_i.x_position;
        yin_q     <= in_item_i.y_position;
        qidx_q    <= in_item_i.buffer_index;
        fb_wr_q   <= 1'b0;
        geom_wr_q <= 1'b0;
        draw_wr_q <= 1'b0;
      end
      OP_LATCH: begin
        fb_wr_q   <= 1'b1;
        geom_wr_q <= 1'b1;
        draw_wr_q <= 1'b1;
      end
      OP_UPDATE: begin
        fb_wr_q   <= disp_go;
        geom_wr_q <= do_pos;
        draw_wr_q <= next_go;
      end
      OP_PIX: begin
        pix_q <= mul_q[PIX_W-1:0];
      end
      OP_ZBUF: begin
        zsize_q <= round_32k(mul_q);
      end
      OP_DRAW_BASE: begin
        draw_base_q <= mul_q;
      end
      OP_SHOW_BASE: begin
        show_base_q <= mul_q;
      end
      OP_QUERY_BASE: begin
        query_base_q <= mul_q;
      end
      default: begin
      end
    endcase
  end

  // At emit the multiplier holds the horizontal offset term of the geometry.
  assign fb_word = WORD_W'(show_base_q >> 13) | (WORD_W'(lay_k_q) << 9) |
                   (WORD_W'(lay_fmt_q) << 15);
  assign geom_word = {20'(lay_height_q) - 20'd1, 44'd0} | (WORD_W'(12'h9ff) << 32) |
                     (WORD_W'(mag_h(lay_k_q)) << 23) | (WORD_W'(y_off_q) << 12) |
                     WORD_W'(mul_q);

  assign shown_x = (IDX_W+OIDX_W)'(shown_q);
  assign drawn_x = (IDX_W+OIDX_W)'(drawn_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_EMIT) begin
      out_q.display_fb_word    <= fb_wr_q ? fb_word : '0;
      out_q.display_fb_write   <= fb_wr_q;
      out_q.display_geom_word  <= geom_wr_q ? geom_word : '0;
      out_q.display_geom_write <= geom_wr_q;
      out_q.draw_frame_base    <= draw_base_q;
      out_q.draw_frame_write   <= draw_wr_q;
      out_q.queried_base       <= (kind_q == KIND_QUERY) ? query_base_q : '0;
      out_q.texture_base       <= tex_q;
      out_q.display_index      <= shown_x[OIDX_W-1:0];
      out_q.draw_index         <= drawn_x[OIDX_W-1:0];
      out_q.draw_available     <= (free_q != '0);
      out_q.display_available  <= (done_q != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == OP_EMIT) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign stat_o.is_setup = (kind_q == KIND_SETUP);
  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign out_item_o      = out_q;

endmodule
